FILE: hw/rtl/hgs_pkg.sv
// Shared types and constants for the heightfield ground snap block.
`timescale 1ns / 1ps
package hgs_pkg;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH = 2'd1;

  localparam logic [8:0] GRID_RESET = 9'd256;
  localparam logic [7:0] HOLE_MAX   = 8'd5;

  // ceil(2^27 / 10): exact divide by ten for values below 2^26
  localparam logic [23:0] RECIP_TEN   = 24'd13421773;
  localparam int          RECIP_SHIFT = 27;

  typedef struct packed {
    logic               mode;
    logic [15:0]        load_addr;
    logic [7:0]         load_height;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
    logic signed [31:0] old_z;
  } in_item_t;

  typedef struct packed {
    logic               on_terrain;
    logic signed [31:0] result_y;
  } out_item_t;

  // One position's cell: grid check, fractions and the four corner bytes
  typedef struct packed {
    logic        in_grid;
    logic [15:0] fx;
    logic [15:0] fz;
    logic [7:0]  h00;
    logic [7:0]  h10;
    logic [7:0]  h01;
    logic [7:0]  h11;
  } corner_set_t;

  typedef struct packed {
    corner_set_t        pn;
    corner_set_t        po;
    logic signed [31:0] py;
    logic signed [31:0] oy;
  } query_set_t;

endpackage

FILE: hw/rtl/hgs_math.sv
// Triangle pick, plane height, distance test and snap decision pipeline.
`timescale 1ns / 1ps
module hgs_math import hgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       q_valid,
  input  query_set_t q,
  output logic       res_valid,
  output out_item_t  res
);

  localparam logic signed [36:0] DIST_FLOOR = -37'sd67108864;

  typedef struct packed {
    logic              ok;
    logic [7:0]        hb;
    logic [16:0]       a;
    logic signed [8:0] da;
    logic [16:0]       b;
    logic signed [8:0] db;
    logic signed [8:0] gx;
    logic signed [8:0] gz;
  } tri_t;

  function automatic logic signed [8:0] hdiff(logic [7:0] p, logic [7:0] m);
    return $signed({1'b0, p}) - $signed({1'b0, m});
  endfunction

  function automatic tri_t pick_tri(corner_set_t c);
    tri_t        t;
    logic [16:0] fsum;
    logic        lower;
    fsum  = {1'b0, c.fx} + {1'b0, c.fz};
    lower = !fsum[16];
    t.ok  = c.in_grid && (c.h10 > HOLE_MAX) && (c.h01 > HOLE_MAX) &&
            (lower ? (c.h00 > HOLE_MAX) : (c.h11 > HOLE_MAX));
    if (lower) begin
      t.hb = c.h00;
      t.a  = {1'b0, c.fx};
      t.da = hdiff(c.h10, c.h00);
      t.b  = {1'b0, c.fz};
      t.db = hdiff(c.h01, c.h00);
      t.gx = hdiff(c.h10, c.h00);
      t.gz = hdiff(c.h01, c.h00);
    end else begin
      t.hb = c.h11;
      t.a  = 17'h10000 - {1'b0, c.fx};
      t.da = hdiff(c.h01, c.h11);
      t.b  = 17'h10000 - {1'b0, c.fz};
      t.db = hdiff(c.h10, c.h11);
      t.gx = hdiff(c.h11, c.h01);
      t.gz = hdiff(c.h11, c.h10);
    end
    return t;
  endfunction

  function automatic logic signed [35:0] times_ten(logic signed [31:0] y);
    logic signed [35:0] ye;
    ye = 36'(y);
    return (ye <<< 3) + (ye <<< 1);
  endfunction

  // stage 1: triangle selection
  logic s1_v_r;
  tri_t s1_tn_r, s1_to_r;
  logic signed [31:0] s1_py_r, s1_oy_r;

  // stage 2: products
  logic s2_v_r;
  logic signed [26:0] s2_p1n_r, s2_p2n_r, s2_p1o_r, s2_p2o_r;
  logic [7:0] s2_hbn_r, s2_hbo_r;
  logic [16:0] s2_gx2_r, s2_gz2_r;
  logic s2_okn_r, s2_oko_r;
  logic signed [35:0] s2_y10n_r, s2_y10o_r;
  logic signed [31:0] s2_py_r;

  // stage 3: plane heights
  logic s3_v_r;
  logic signed [26:0] s3_tn_r, s3_to_r;
  logic [17:0] s3_g_r;
  logic s3_okn_r, s3_oko_r;
  logic signed [35:0] s3_y10n_r, s3_y10o_r;
  logic signed [31:0] s3_py_r;

  // stage 4: compares and distance
  logic s4_v_r;
  logic s4_le_r, s4_dpos_r, s4_dsmall_r, s4_okn_r, s4_oko_r;
  logic [24:0] s4_tr_r;
  logic [25:0] s4_dmag_r;
  logic [17:0] s4_g_r;
  logic signed [31:0] s4_py_r;

  // stage 5: squares and reciprocal product
  logic s5_v_r;
  logic [51:0] s5_sq_r;
  logic [48:0] s5_qm_r;
  logic s5_le_r, s5_dpos_r, s5_dsmall_r, s5_okn_r, s5_oko_r;
  logic [17:0] s5_g_r;
  logic signed [31:0] s5_py_r;

  logic signed [17:0] gx2_full, gz2_full;
  logic signed [36:0] d_old;
  logic [57:0] lhs, rhs;
  logic dist_ok, snap;

  always_comb begin
    gx2_full = 18'(s1_to_r.gx) * 18'(s1_to_r.gx);
    gz2_full = 18'(s1_to_r.gz) * 18'(s1_to_r.gz);
    d_old    = 37'(s3_y10o_r) - 37'(s3_to_r);
    lhs      = (58'(s5_sq_r) << 4) + (58'(s5_sq_r) << 3) + 58'(s5_sq_r);
    rhs      = {8'd0, s5_g_r, 32'd0};
    dist_ok  = s5_oko_r && (s5_dpos_r || (s5_dsmall_r && (lhs <= rhs)));
    snap     = s5_okn_r && s5_le_r && dist_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tn_r <= pick_tri(q.pn);
      s1_to_r <= pick_tri(q.po);
      s1_py_r <= q.py;
      s1_oy_r <= q.oy;

      s2_p1n_r  <= $signed({10'd0, s1_tn_r.a}) * 27'(s1_tn_r.da);
      s2_p2n_r  <= $signed({10'd0, s1_tn_r.b}) * 27'(s1_tn_r.db);
      s2_p1o_r  <= $signed({10'd0, s1_to_r.a}) * 27'(s1_to_r.da);
      s2_p2o_r  <= $signed({10'd0, s1_to_r.b}) * 27'(s1_to_r.db);
      s2_hbn_r  <= s1_tn_r.hb;
      s2_hbo_r  <= s1_to_r.hb;
      s2_gx2_r  <= gx2_full[16:0];
      s2_gz2_r  <= gz2_full[16:0];
      s2_okn_r  <= s1_tn_r.ok;
      s2_oko_r  <= s1_to_r.ok;
      s2_y10n_r <= times_ten(s1_py_r);
      s2_y10o_r <= times_ten(s1_oy_r);
      s2_py_r   <= s1_py_r;

      s3_tn_r   <= $signed({3'd0, s2_hbn_r, 16'd0}) + s2_p1n_r + s2_p2n_r;
      s3_to_r   <= $signed({3'd0, s2_hbo_r, 16'd0}) + s2_p1o_r + s2_p2o_r;
      s3_g_r    <= 18'd100 + 18'(s2_gx2_r) + 18'(s2_gz2_r);
      s3_okn_r  <= s2_okn_r;
      s3_oko_r  <= s2_oko_r;
      s3_y10n_r <= s2_y10n_r;
      s3_y10o_r <= s2_y10o_r;
      s3_py_r   <= s2_py_r;

      s4_le_r     <= s3_y10n_r <= 36'(s3_tn_r);
      s4_tr_r     <= 25'(s3_tn_r) + 25'd5;
      s4_dpos_r   <= !d_old[36];
      s4_dsmall_r <= d_old > DIST_FLOOR;
      s4_dmag_r   <= 26'(-d_old);
      s4_g_r      <= s3_g_r;
      s4_okn_r    <= s3_okn_r;
      s4_oko_r    <= s3_oko_r;
      s4_py_r     <= s3_py_r;

      s5_sq_r     <= 52'(s4_dmag_r) * 52'(s4_dmag_r);
      s5_qm_r     <= 49'(s4_tr_r) * 49'(RECIP_TEN);
      s5_le_r     <= s4_le_r;
      s5_dpos_r   <= s4_dpos_r;
      s5_dsmall_r <= s4_dsmall_r;
      s5_g_r      <= s4_g_r;
      s5_okn_r    <= s4_okn_r;
      s5_oko_r    <= s4_oko_r;
      s5_py_r     <= s4_py_r;
    end
  end

  assign res_valid      = s5_v_r;
  assign res.on_terrain = snap;
  assign res.result_y   = snap ? $signed(32'(s5_qm_r >> RECIP_SHIFT)) : s5_py_r;

endmodule

FILE: hw/rtl/heightfield_ground_snap.sv
// Top level: height store, corner read sequencer, config registers, output stage.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_item_t (load or query)
//   out_     output     out_valid/out_stall  out_item_t (one per query)
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_wdata (9 bits)
//
// A query stalls the input while its corner reads run: each of the two store
// copies has one read port and serves four corner reads, one copy for the old
// position, one for the new. out_valid rises once the last corner read has passed
// the hgs_math stages and the output register. Reset clears control and sets both
// grid sizes to 256; store contents are undefined until loaded. A full output
// register under out_stall freezes all but config writes and raises in_stall.
`timescale 1ns / 1ps
module heightfield_ground_snap import hgs_pkg::*; #(
  parameter int GRID_SIDE_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);

  logic [8:0] grid_width_r, grid_depth_r, w_eff, d_eff;

  logic adv, accept, load_acc, query_acc;
  logic rd_act_r, rd_pend_r;
  logic [1:0] ph_r, rd_idx_r;
  logic [15:0] base_o_r, base_n_r, addr_o, addr_n, offs;
  query_set_t qi_r, cap_r, q_bus;

  logic [7:0] mem_o [0:65535];
  logic [7:0] mem_n [0:65535];
  logic [7:0] mem_o_q, mem_n_q;

  logic       res_valid;
  out_item_t  res;
  logic       out_valid_r;
  out_item_t  out_data_r;

  function automatic logic cell_ok(logic [31:0] x, logic [31:0] z,
                                   logic [8:0] w, logic [8:0] d);
    logic [15:0] wl, dl;
    wl = {7'd0, w} - 16'd1;
    dl = {7'd0, d} - 16'd1;
    return !x[31] && !z[31] && (w >= 9'd2) && (d >= 9'd2) &&
           (x[31:16] < wl) && (z[31:16] < dl);
  endfunction

  function automatic logic [15:0] cell_base(logic [31:0] x, logic [31:0] z,
                                            logic [8:0] w);
    logic [24:0] prod;
    prod = 25'(z[31:16]) * 25'(w) + 25'(x[31:16]);
    return prod[15:0];
  endfunction

  assign w_eff = (int'(grid_width_r) > GRID_SIDE_MAX) ? 9'(GRID_SIDE_MAX) : grid_width_r;
  assign d_eff = (int'(grid_depth_r) > GRID_SIDE_MAX) ? 9'(GRID_SIDE_MAX) : grid_depth_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv || (rd_act_r && (ph_r != 2'd3));
  assign accept    = in_valid && !in_stall;
  assign load_acc  = accept && (in_data.mode == MODE_LOAD);
  assign query_acc = accept && (in_data.mode == MODE_QUERY);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GRID_RESET;
      grid_depth_r <= GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: grid_width_r <= cfg_wdata;
        REG_GRID_DEPTH: grid_depth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // corner offsets: (0,0) (1,0) (0,1) (1,1)
  always_comb begin
    case (ph_r)
      2'd0:    offs = 16'd0;
      2'd1:    offs = 16'd1;
      2'd2:    offs = {7'd0, w_eff};
      default: offs = {7'd0, w_eff} + 16'd1;
    endcase
    addr_o = base_o_r + offs;
    addr_n = base_n_r + offs;
  end

  // read sequencer; hand over on the last read so the next query can start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r  <= 1'b0;
      ph_r      <= 2'd0;
      rd_pend_r <= 1'b0;
      rd_idx_r  <= 2'd0;
    end else if (adv) begin
      rd_pend_r <= rd_act_r;
      rd_idx_r  <= ph_r;
      if (query_acc) begin
        rd_act_r <= 1'b1;
        ph_r     <= 2'd0;
      end else if (rd_act_r && (ph_r == 2'd3)) begin
        rd_act_r <= 1'b0;
      end else if (rd_act_r) begin
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (query_acc) begin
        base_o_r        <= cell_base(in_data.old_x, in_data.old_z, w_eff);
        base_n_r        <= cell_base(in_data.pos_x, in_data.pos_z, w_eff);
        qi_r.po.in_grid <= cell_ok(in_data.old_x, in_data.old_z, w_eff, d_eff);
        qi_r.pn.in_grid <= cell_ok(in_data.pos_x, in_data.pos_z, w_eff, d_eff);
        qi_r.po.fx      <= in_data.old_x[15:0];
        qi_r.po.fz      <= in_data.old_z[15:0];
        qi_r.pn.fx      <= in_data.pos_x[15:0];
        qi_r.pn.fz      <= in_data.pos_z[15:0];
        qi_r.py         <= in_data.pos_y;
        qi_r.oy         <= in_data.old_y;
      end
      if (rd_act_r && (ph_r == 2'd3)) begin
        cap_r.po.in_grid <= qi_r.po.in_grid;
        cap_r.pn.in_grid <= qi_r.pn.in_grid;
        cap_r.po.fx      <= qi_r.po.fx;
        cap_r.po.fz      <= qi_r.po.fz;
        cap_r.pn.fx      <= qi_r.pn.fx;
        cap_r.pn.fz      <= qi_r.pn.fz;
        cap_r.py         <= qi_r.py;
        cap_r.oy         <= qi_r.oy;
      end
      if (rd_pend_r) begin
        case (rd_idx_r)
          2'd0: begin
            cap_r.po.h00 <= mem_o_q;
            cap_r.pn.h00 <= mem_n_q;
          end
          2'd1: begin
            cap_r.po.h10 <= mem_o_q;
            cap_r.pn.h10 <= mem_n_q;
          end
          2'd2: begin
            cap_r.po.h01 <= mem_o_q;
            cap_r.pn.h01 <= mem_n_q;
          end
          default: ;
        endcase
      end
    end
  end

  // two store copies, written together, read one corner a cycle each unless stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      mem_o_q <= mem_o[addr_o];
      mem_n_q <= mem_n[addr_n];
    end
    if (load_acc) begin
      mem_o[in_data.load_addr] <= in_data.load_height;
      mem_n[in_data.load_addr] <= in_data.load_height;
    end
  end

  // last corner goes straight from the read register
  always_comb begin
    q_bus        = cap_r;
    q_bus.po.h11 = mem_o_q;
    q_bus.pn.h11 = mem_n_q;
  end

  hgs_math u_math (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .q_valid   (rd_pend_r && (rd_idx_r == 2'd3)),
    .q         (q_bus),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/hgs_checker.sv
// Port-level checks for the heightfield ground snap block, bound to the top.
`timescale 1ns / 1ps
module hgs_checker import hgs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat straight after reset");

  // a query keeps the store ports busy, so the next beat is stalled
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.mode == MODE_QUERY) |=> in_stall)
    else $error("beat taken during corner reads");

  // snapped heights are non-negative and below 2^21
  a_snap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.on_terrain |-> out_data.result_y[31:21] == 11'd0)
    else $error("snapped height out of range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind heightfield_ground_snap hgs_checker u_hgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

FILE: sim/hgs_checker.sv
// Checker: tracks config and height store, predicts snap results, compares output beats.
`timescale 1ns / 1ps
module hgs_tb_checker import hgs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  output int         errors,
  output int         pending,
  output int         snaps
);

  logic [7:0] height_mem [0:65535];
  logic [8:0] width_reg, depth_reg;
  out_item_t  expected_q [$];

  initial begin
    for (int i = 0; i < 65536; i++) height_mem[i] = 8'd0;
    errors = 0;
    snaps  = 0;
  end

  assign pending = expected_q.size();

  function automatic longint eff_side(logic [8:0] s);
    return (s > 9'd256) ? 256 : longint'(s);
  endfunction

  function automatic bit terrain_height(longint x, longint z, output longint t,
                                        output longint gx, output longint gz);
    longint w, d, cx, cz, fx, fz, base, h00, h10, h01, h11;
    w = eff_side(width_reg);
    d = eff_side(depth_reg);
    t = 0; gx = 0; gz = 0;
    if (x < 0 || z < 0 || w < 2 || d < 2) return 0;
    cx = x >>> 16;
    cz = z >>> 16;
    if (cx >= w - 1 || cz >= d - 1) return 0;
    fx = x & 16'hFFFF;
    fz = z & 16'hFFFF;
    base = cz * w + cx;
    h00 = height_mem[base[15:0]];
    h10 = height_mem[16'(base + 1)];
    h01 = height_mem[16'(base + w)];
    h11 = height_mem[16'(base + w + 1)];
    if (h10 <= HOLE_MAX || h01 <= HOLE_MAX) return 0;
    if (fx + fz < 65536) begin
      if (h00 <= HOLE_MAX) return 0;
      gx = h10 - h00;
      gz = h01 - h00;
      t = h00 * 65536 + fx * (h10 - h00) + fz * (h01 - h00);
    end else begin
      if (h11 <= HOLE_MAX) return 0;
      gx = h11 - h01;
      gz = h11 - h10;
      t = h11 * 65536 + (65536 - fx) * (h01 - h11) + (65536 - fz) * (h10 - h11);
    end
    return 1;
  endfunction

  function automatic out_item_t predict_snap(in_item_t it);
    out_item_t r;
    longint tn, gxn, gzn, to, gxo, gzo, dd;
    bit new_ok, old_ok, dist_ok;
    dist_ok = 0;
    old_ok = terrain_height(longint'(it.old_x), longint'(it.old_z), to, gxo, gzo);
    new_ok = terrain_height(longint'(it.pos_x), longint'(it.pos_z), tn, gxn, gzn);
    if (old_ok) begin
      dd = longint'(it.old_y) * 10 - to;
      if (dd >= 0) dist_ok = 1;
      else if (dd > -(64'sd1 <<< 26))
        dist_ok = (dd * dd * 25) <= ((100 + gxo * gxo + gzo * gzo) <<< 32);
    end
    if (new_ok && longint'(it.pos_y) * 10 <= tn && dist_ok) begin
      r.on_terrain = 1'b1;
      r.result_y   = 32'((tn + 5) / 10);
    end else begin
      r.on_terrain = 1'b0;
      r.result_y   = it.pos_y;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      width_reg <= GRID_RESET;
      depth_reg <= GRID_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_WIDTH) width_reg <= cfg_wdata;
        else if (cfg_index == REG_GRID_DEPTH) depth_reg <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_LOAD) height_mem[in_data.load_addr] = in_data.load_height;
        else expected_q.push_back(predict_snap(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", out_data);
        end else begin
          exp_item = expected_q.pop_front();
          if (exp_item.on_terrain) snaps++;
          if (exp_item.on_terrain !== out_data.on_terrain ||
              exp_item.result_y !== out_data.result_y) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected on_terrain=%0d y=%0d, got on_terrain=%0d y=%0d",
                       exp_item.on_terrain, exp_item.result_y,
                       out_data.on_terrain, out_data.result_y);
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb_heightfield_ground_snap.sv
// Testbench top: clock, reset, load/query stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_heightfield_ground_snap import hgs_pkg::*;;

  logic       clk, rst_n;
  logic       in_valid, in_stall, out_valid, out_stall;
  logic       cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;
  in_item_t   in_data;
  out_item_t  out_data;
  int         errors, pending, snaps;

  bit         written [0:65535];
  int         grid_w, grid_d, win_c0, win_r0, win_nc, win_nr;
  int         burst_left, idle_cycles, n_loads, n_queries, n_phases;
  int         stall_mode;

  heightfield_ground_snap dut (.*);

  hgs_tb_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= 5000) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("RESULT: ERROR");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // receiver stall: the stall mode is changed at random times
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic push(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (it.mode == MODE_LOAD) n_loads++;
    else n_queries++;
  endtask

  task automatic load(input int addr, input int hgt);
    in_item_t    it;
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    it.mode        = MODE_LOAD;
    it.load_addr   = 16'(addr);
    it.load_height = 8'(hgt);
    written[16'(addr)] = 1;
    push(it);
  endtask

  task automatic query(input logic [31:0] x, y, z, ox, oy, oz);
    in_item_t it;
    it.mode        = MODE_QUERY;
    it.load_addr   = 16'($urandom);
    it.load_height = 8'($urandom);
    it.pos_x = x; it.pos_y = y; it.pos_z = z;
    it.old_x = ox; it.old_y = oy; it.old_z = oz;
    push(it);
  endtask

  // a position is safe when it reads no store entry that was never written
  function automatic bit safe_pos(logic [31:0] x, logic [31:0] z);
    int cx, cz, base;
    if (x[31] || z[31] || grid_w < 2 || grid_d < 2) return 1;
    cx = x[31:16];
    cz = z[31:16];
    if (cx >= grid_w - 1 || cz >= grid_d - 1) return 1;
    base = cz * grid_w + cx;
    return written[16'(base)] && written[16'(base + 1)] &&
           written[16'(base + grid_w)] && written[16'(base + grid_w + 1)];
  endfunction

  function automatic logic [31:0] window_coord(int lo, int n);
    return {16'(lo + $urandom_range(0, n - 2)), 16'($urandom)};
  endfunction

  function automatic int rand_height();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 255);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drain outstanding results, then let any trailing load settle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_grid(input int w, input int d);
    drain();
    write_reg(REG_GRID_WIDTH, 9'(w));
    write_reg(REG_GRID_DEPTH, 9'(d));
    grid_w = (w > 256) ? 256 : w;
    grid_d = (d > 256) ? 256 : d;
    n_phases++;
    if (grid_w >= 2 && grid_d >= 2) begin
      win_nc = (grid_w < 8) ? grid_w : 8;
      win_nr = (grid_d < 8) ? grid_d : 8;
      // favour the far edge so the last cell column and row get exercised
      win_c0 = $urandom_range(0, 1) ? grid_w - win_nc : $urandom_range(0, grid_w - win_nc);
      win_r0 = $urandom_range(0, 1) ? grid_d - win_nr : $urandom_range(0, grid_d - win_nr);
      for (int r = 0; r < win_nr; r++)
        for (int c = 0; c < win_nc; c++)
          load((win_r0 + r) * grid_w + win_c0 + c, rand_height());
    end
  endtask

  task automatic random_phase(input int n);
    logic [31:0] x, y, z, ox, oy, oz;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        if (grid_w >= 2 && grid_d >= 2 && $urandom_range(0, 1))
          load((win_r0 + $urandom_range(0, win_nr - 1)) * grid_w + win_c0 +
               $urandom_range(0, win_nc - 1), rand_height());
        else load($urandom_range(0, 65535), $urandom_range(0, 255));
      end else begin
        if (grid_w >= 2 && grid_d >= 2 && $urandom_range(0, 4) != 0) begin
          x = window_coord(win_c0, win_nc);
          z = window_coord(win_r0, win_nr);
        end else begin
          x = $urandom;
          z = $urandom;
        end
        if ($urandom_range(0, 2) != 0) begin
          ox = x + 32'($urandom_range(0, 65535)) - 32'd32768;
          oz = z + 32'($urandom_range(0, 65535)) - 32'd32768;
        end else begin
          ox = $urandom;
          oz = $urandom;
        end
        if (!safe_pos(x, z) && grid_w >= 2 && grid_d >= 2) begin
          x = window_coord(win_c0, win_nc);
          z = window_coord(win_r0, win_nr);
        end
        if (!safe_pos(ox, oz)) begin
          ox = x;
          oz = z;
        end
        y  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 27 << 16));
        oy = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 27 << 16));
        query(x, y, z, ox, oy, oz);
      end
    end
  endtask

  initial begin
    in_valid = 0; in_data = '0; out_stall = 0; cfg_valid = 0; cfg_index = REG_GRID_WIDTH;
    cfg_wdata = '0; rst_n = 0; burst_left = 0; idle_cycles = 0; stall_mode = 0;
    n_loads = 0; n_queries = 0; n_phases = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // directed: 4x4 grid with holes and extreme bytes
    grid_w = 4; grid_d = 4;
    drain();
    write_reg(REG_GRID_WIDTH, 9'd4);
    write_reg(REG_GRID_DEPTH, 9'd4);
    n_phases++;
    win_c0 = 0; win_r0 = 0; win_nc = 4; win_nr = 4;
    foreach (written[i]) written[i] = 0;
    begin
      int hmap [16] = '{20, 30, 40, 255, 25, 6, 50, 60, 5, 0, 70, 80, 100, 110, 120, 130};
      for (int i = 0; i < 16; i++) load(i, hmap[i]);
    end
    query(32'h0, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0);                    // cell corner
    query(32'h8000, 32'h0, 32'h8000, 32'h8000, 32'h0, 32'h8000);                // diagonal seam
    query(32'hFFFF, 32'h0, 32'hFFFF, 32'h7FFF, 32'h0, 32'h7FFF);
    query(32'h0002_4000, 32'h8000_0000, 32'h0002_8000, 32'h0002_4000, 32'h7FFF_FFFF,
          32'h0002_8000);                                                      // deep below
    query(32'h0002_4000, 32'h7FFF_FFFF, 32'h0002_8000, 32'h0002_4000, 32'h0, 32'h0002_8000);
    query(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);                    // negative x
    query(32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    query(32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);                    // last column
    query(32'h0, 32'h0, 32'h0003_0000, 32'h0, 32'h0, 32'h0);                    // last row
    query(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    query(32'h0000_4000, 32'h0, 32'h0001_4000, 32'h0, 32'h0, 32'h0);            // hole triangle
    query(32'h0002_4000, 32'h0, 32'h0002_4000, 32'hFFFF_FFFF, 32'h0, 32'h0);    // old off grid
    query(32'h0002_4000, 32'h0, 32'h0002_4000, 32'h0002_4000, 32'h8000_0000, 32'h0002_4000);
    query(32'h0002_4000, 32'h0, 32'h0002_4000, 32'h0002_4000, 32'h0006_0000, 32'h0002_4000);
    random_phase(200);

    set_grid(2, 2);      random_phase(130);
    set_grid(256, 2);    random_phase(110);
    set_grid(2, 256);    random_phase(110);
    set_grid(511, 511);  random_phase(120);
    set_grid(0, 7);      random_phase(40);
    set_grid(9, 1);      random_phase(40);
    set_grid(300, 3);    random_phase(110);
    set_grid(256, 256);  random_phase(120);
    set_grid($urandom_range(2, 20), $urandom_range(2, 20)); random_phase(130);
    set_grid($urandom_range(0, 511), $urandom_range(0, 511)); random_phase(100);

    drain();
    $display("covered %0d loads and %0d queries over %0d grid settings, %0d snapped",
             n_loads, n_queries, n_phases, snaps);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
